/* hdl/mrra_pkg.sv */
// Shared types and constants for the mark/release region allocator.
// No dependencies; imported by every module of the block.
`default_nettype none

package mrra_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned MARKS_W = 8;

    // Request kinds carried on the func field
    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FREE  = 2'd1;
    localparam logic [1:0] FUNC_RESET = 2'd2;

    // Configuration register indexes
    localparam logic CFG_POOL_BASE = 1'b0;
    localparam logic CFG_POOL_SIZE = 1'b1;

    // One history entry: pointer and space left at the time of the push
    typedef struct packed {
        logic [DATA_W-1:0] addr;
        logic [DATA_W-1:0] space;
    } mark_t;

    // One result item
    typedef struct packed {
        logic [DATA_W-1:0]  addr;
        logic               granted;
        logic [MARKS_W-1:0] marks;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ROUND = 3'b010,
        ST_POP   = 3'b100
    } state_t;

endpackage

`default_nettype wire

/* hdl/mark_release_region_allocator_core.sv */
// Mark/release region allocator: bump pointer with a history stack in RAM.
// Depends on mrra_pkg, mrra_round_unit and mrra_mark_ram.
`default_nettype none

// Usage
//   Request channel (in_valid/in_ready, func, request_size): one transfer per
//   request. Result channel (out_valid/out_ready, block_address, granted,
//   marks_held): exactly one transfer per request, in request order.
//   Config port: cfg_write_en with cfg_index/cfg_wdata writes pool_base (0)
//   or pool_size (1); values are used at the next reset-region request.
// Result path (request transfer to out_valid)
//   allocate, reset region, empty free, unused code: the result register only.
//   free with marks held: the history RAM read, then the result register.
//   allocate with a non-power-of-two ALIGN_BYTES: the three register stages
//   of the reciprocal remainder unit, then the result register.
// Throughput
//   one allocate or reset per cycle with power-of-two alignment while the skid
//   entry is free; a free with marks held holds the request side during its RAM read.
// Reset: pointer, space, mark count, pool config and valid flags clear to zero;
//   the history RAM needs no clearing, pops only read entries below the mark count.
// Stall: a result register plus one skid entry; a new request is taken while
//   one result waits, and in_ready drops once the skid entry is occupied.
module mark_release_region_allocator_core #(
    parameter int unsigned MARK_DEPTH    = 128,
    parameter int unsigned ALIGN_BYTES   = 64,
    parameter int unsigned CMD_BUF_BYTES = 32768
) (
    input  wire                          clk,
    input  wire                          rst_n,
    // configuration
    input  wire                          cfg_write_en,
    input  wire                          cfg_index,
    input  wire  [mrra_pkg::DATA_W-1:0]  cfg_wdata,
    // requests
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  [1:0]                   func,
    input  wire  [mrra_pkg::DATA_W-1:0]  request_size,
    // results
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [mrra_pkg::DATA_W-1:0]  block_address,
    output logic                         granted,
    output logic [mrra_pkg::MARKS_W-1:0] marks_held
);
    import mrra_pkg::*;

    localparam int unsigned CNT_W = $clog2(MARK_DEPTH + 1);
    localparam int unsigned AW    = $clog2(MARK_DEPTH);
    localparam logic [CNT_W-1:0]  CNT_FULL    = CNT_W'(MARK_DEPTH);
    localparam logic [DATA_W-1:0] CMD_ROUNDED =
        DATA_W'(((CMD_BUF_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES);

    // control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DATA_W-1:0] next_addr_reg, next_addr_next;
    logic [DATA_W-1:0] space_reg, space_next;
    logic [DATA_W-1:0] pool_base_reg, pool_size_reg;

    // output stage
    logic out_valid_reg, skid_valid_reg;
    res_t out_res_reg, skid_res_reg;

    // datapath
    logic              in_fire;
    logic              rnd_start, rnd_done;
    logic [DATA_W:0]   rnd_rounded;
    logic              alloc_ok;
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    mark_t             ram_wdata, ram_rdata;
    logic              res_valid;
    res_t              res;

    assign in_ready  = (state_reg == ST_IDLE) && !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign rnd_start = in_fire && (func == FUNC_ALLOC);

    mrra_round_unit #(
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_round (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (rnd_start),
        .size    (request_size),
        .done    (rnd_done),
        .rounded (rnd_rounded)
    );

    // Push and pop never fall in the same cycle, and a pop read is issued in a
    // later cycle than the push that wrote the entry: no forwarding needed.
    mrra_mark_ram #(
        .DEPTH (MARK_DEPTH)
    ) u_marks (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // rounding overflow, full history and short space all refuse
    assign alloc_ok = !rnd_rounded[DATA_W]
                   && (count_reg != CNT_FULL)
                   && (rnd_rounded[DATA_W-1:0] <= space_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        next_addr_next = next_addr_reg;
        space_next     = space_reg;
        ram_we         = 1'b0;
        ram_waddr      = AW'(count_reg);
        ram_wdata      = '{addr: next_addr_reg, space: space_reg};
        ram_re         = 1'b0;
        ram_raddr      = AW'(count_reg - 1'b1);
        res_valid      = 1'b0;
        res            = '{addr: '0, granted: 1'b0, marks: MARKS_W'(count_reg)};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (func)
                        FUNC_ALLOC:
                        begin
                            if (rnd_done)
                            begin
                                res_valid = 1'b1;
                                if (alloc_ok)
                                begin
                                    ram_we         = 1'b1;
                                    count_next     = count_reg + 1'b1;
                                    next_addr_next = next_addr_reg + rnd_rounded[DATA_W-1:0];
                                    space_next     = space_reg - rnd_rounded[DATA_W-1:0];
                                    res            = '{addr: next_addr_reg, granted: 1'b1,
                                                       marks: MARKS_W'(count_reg + 1'b1)};
                                end
                            end
                            else
                            begin
                                state_next = ST_ROUND;
                            end
                        end
                        FUNC_FREE:
                        begin
                            if (count_reg != '0)
                            begin
                                ram_re     = 1'b1;
                                state_next = ST_POP;
                            end
                            else
                            begin
                                res_valid = 1'b1;
                            end
                        end
                        FUNC_RESET:
                        begin
                            // reload always happens; the command buffer may still fail
                            res_valid = 1'b1;
                            if (CMD_ROUNDED <= pool_size_reg)
                            begin
                                ram_we         = 1'b1;
                                ram_waddr      = '0;
                                ram_wdata      = '{addr: pool_base_reg, space: pool_size_reg};
                                count_next     = CNT_W'(1);
                                next_addr_next = pool_base_reg + CMD_ROUNDED;
                                space_next     = pool_size_reg - CMD_ROUNDED;
                                res            = '{addr: pool_base_reg, granted: 1'b1,
                                                   marks: MARKS_W'(1)};
                            end
                            else
                            begin
                                count_next     = '0;
                                next_addr_next = pool_base_reg;
                                space_next     = pool_size_reg;
                                res            = '{addr: '0, granted: 1'b0, marks: '0};
                            end
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_ROUND:
            begin
                if (rnd_done)
                begin
                    state_next = ST_IDLE;
                    res_valid  = 1'b1;
                    if (alloc_ok)
                    begin
                        ram_we         = 1'b1;
                        count_next     = count_reg + 1'b1;
                        next_addr_next = next_addr_reg + rnd_rounded[DATA_W-1:0];
                        space_next     = space_reg - rnd_rounded[DATA_W-1:0];
                        res            = '{addr: next_addr_reg, granted: 1'b1,
                                           marks: MARKS_W'(count_reg + 1'b1)};
                    end
                end
            end
            ST_POP:
            begin
                // RAM data for entry count-1 arrives this cycle
                state_next     = ST_IDLE;
                res_valid      = 1'b1;
                count_next     = count_reg - 1'b1;
                next_addr_next = ram_rdata.addr;
                space_next     = ram_rdata.space;
                res            = '{addr: ram_rdata.addr, granted: 1'b1,
                                   marks: MARKS_W'(count_reg - 1'b1)};
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            next_addr_reg <= '0;
            space_reg     <= '0;
            pool_base_reg <= '0;
            pool_size_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            next_addr_reg <= next_addr_next;
            space_reg     <= space_next;
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    CFG_POOL_BASE: pool_base_reg <= cfg_wdata;
                    CFG_POOL_SIZE: pool_size_reg <= cfg_wdata;
                    default:       pool_base_reg <= pool_base_reg;
                endcase
            end
        end
    end

    // result register plus skid entry
    logic out_take;
    assign out_take = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_res_reg <= skid_res_reg;
            end
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_res_reg <= res;
            end
            else
            begin
                out_res_reg <= res;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign block_address = out_res_reg.addr;
    assign granted       = out_res_reg.granted;
    assign marks_held    = out_res_reg.marks;

    // mark count stays within the stack depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("mark count beyond stack depth");

    // the RAM is never pushed and popped in one cycle
    a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("push and pop in the same cycle");

    // a pop completes only after its read was issued
    a_pop_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |-> $past(ram_re))
        else $error("pop without a preceding RAM read");

    // the skid entry is only used behind a full result register
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty result register");

endmodule

`default_nettype wire

/* hdl/mrra_mark_ram.sv */
// History stack storage: one write port, one read port, registered read data.
// Depends on mrra_pkg (mark_t).
`default_nettype none

module mrra_mark_ram #(
    parameter int unsigned DEPTH = 128
) (
    input  wire                         clk,
    input  wire                         we,
    input  wire  [$clog2(DEPTH)-1:0]    waddr,
    input  mrra_pkg::mark_t             wdata,
    input  wire                         re,
    input  wire  [$clog2(DEPTH)-1:0]    raddr,
    output mrra_pkg::mark_t             rdata
);
    import mrra_pkg::*;

    mark_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/mrra_round_unit.sv */
// Rounds a request size up to a multiple of ALIGN_BYTES (33-bit result).
// Power-of-two alignment is a mask; otherwise a three-stage reciprocal remainder.
// Depends on mrra_pkg (DATA_W).
`default_nettype none

module mrra_round_unit #(
    parameter int unsigned ALIGN_BYTES = 64
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    input  wire  [mrra_pkg::DATA_W-1:0] size,
    output logic                        done,
    output logic [mrra_pkg::DATA_W:0]   rounded
);
    import mrra_pkg::*;

    localparam bit IS_POW2 = ((ALIGN_BYTES & (ALIGN_BYTES - 1)) == 0);

    generate
        if (IS_POW2)
        begin : g_mask
            localparam logic [DATA_W:0] LOW_MASK = (DATA_W+1)'(ALIGN_BYTES - 1);

            // result is ready in the cycle of the request
            assign done    = start;
            assign rounded = ((DATA_W+1)'(size) + LOW_MASK) & ~LOW_MASK;
        end
        else
        begin : g_recip
            // floor(size * RECIP / 2^32) is the quotient or one below it,
            // so one compare and subtract finishes the remainder
            localparam int unsigned RW = $clog2(ALIGN_BYTES) + 1;
            localparam logic [DATA_W-1:0] RECIP =
                DATA_W'((64'd1 << DATA_W) / 64'(ALIGN_BYTES));
            localparam logic [RW-1:0] ALIGN_R = RW'(ALIGN_BYTES);

            logic [2:0]          stage_reg, stage_next;
            logic [DATA_W-1:0]   size_reg, size_next;
            logic [DATA_W-1:0]   quot_reg, quot_next;
            logic [RW-1:0]       rem_reg, rem_next;
            logic [2*DATA_W-1:0] prod;
            logic [RW-1:0]       rem_est;

            // stage 0: quotient estimate; stage 1: remainder; stage 2: result
            always_comb
            begin
                prod       = (2*DATA_W)'(size_reg) * (2*DATA_W)'(RECIP);
                // true remainder estimate is below 2*ALIGN_BYTES, low bits suffice
                rem_est    = RW'(size_reg) - RW'(quot_reg) * ALIGN_R;
                stage_next = {stage_reg[1:0], start};
                size_next  = start ? size : size_reg;
                quot_next  = stage_reg[0] ? prod[2*DATA_W-1:DATA_W] : quot_reg;
                rem_next   = rem_reg;
                if (stage_reg[1])
                begin
                    rem_next = (rem_est >= ALIGN_R) ? (rem_est - ALIGN_R) : rem_est;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    stage_reg <= '0;
                end
                else
                begin
                    stage_reg <= stage_next;
                end
            end

            always_ff @(posedge clk)
            begin
                size_reg <= size_next;
                quot_reg <= quot_next;
                rem_reg  <= rem_next;
            end

            assign done    = stage_reg[2];
            assign rounded = (rem_reg == '0)
                           ? {1'b0, size_reg}
                           : ({1'b0, size_reg} + (DATA_W+1)'(ALIGN_BYTES))
                             - (DATA_W+1)'(rem_reg);
        end
    endgenerate

endmodule

`default_nettype wire
